// ===== src/fpadd_pkg.sv =====
`default_nettype none
package fpadd_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned EXP_W  = 8;
   localparam int unsigned FRAC_W = 23;
   localparam int unsigned SIG_W  = 24;
   // Working significand: 24 bits plus guard, round and sticky, plus a carry bit.
   localparam int unsigned WORK_W = 28;
   localparam int unsigned LZC_W  = 5;
   localparam int unsigned STAT_W = 2;
   localparam logic [EXP_W-1:0]  EXP_MAX   = 8'hFF;
   localparam logic [WORD_W-1:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd2;

   // Result of stage one, after operand ordering and alignment.
   typedef struct packed {
      logic              invalid;
      logic              sub;
      logic              sign;
      logic [EXP_W-1:0]  exp;
      logic [WORK_W-2:0] mx;
      logic [WORK_W-2:0] my;
   } align_type;

   // Result of stage two, after the add and the leading-zero count.
   typedef struct packed {
      logic              invalid;
      logic              zero;
      logic              sub;
      logic              sign;
      logic [EXP_W-1:0]  exp;
      logic [WORK_W-1:0] sum;
      logic [LZC_W-1:0]  lzc;
   } addsum_type;

   // Result of stage three, after normalization.
   typedef struct packed {
      logic              invalid;
      logic              zero;
      logic              sub;
      logic              sign;
      logic [EXP_W:0]    exp;
      logic [WORK_W-2:0] sum;
   } norm_type;
endpackage
`default_nettype wire

// ===== src/fpadd_align.sv =====
`default_nettype none
module fpadd_align (
   input  wire logic [fpadd_pkg::WORD_W-1:0] operand_a,
   input  wire logic [fpadd_pkg::WORD_W-1:0] operand_b,
   output fpadd_pkg::align_type              result
);
   import fpadd_pkg::*;

   logic [WORD_W-1:0] big, lesser;
   logic [EXP_W-1:0]  ex, ey, d;
   logic [WORK_W-2:0] mx, my, mask;
   logic              lost;

   always_comb begin
      mask = '0;
      lost = 1'b0;
      if (operand_a[WORD_W-2:0] >= operand_b[WORD_W-2:0]) begin
         big = operand_a; lesser = operand_b;
      end else begin
         big = operand_b; lesser = operand_a;
      end
      ex = big[WORD_W-2 -: EXP_W];
      ey = lesser[WORD_W-2 -: EXP_W];
      mx = {(ex != '0), big[FRAC_W-1:0], 3'b000};
      my = {(ey != '0), lesser[FRAC_W-1:0], 3'b000};
      if (ex == '0) ex = 8'd1;
      if (ey == '0) ey = 8'd1;
      d = ex - ey;
      if (d >= 8'(WORK_W-1)) begin
         my = {{(WORK_W-2){1'b0}}, (my != '0)};
      end else begin
         mask = ~({(WORK_W-1){1'b1}} << d[LZC_W-1:0]);
         lost = (my & mask) != '0;
         my   = (my >> d[LZC_W-1:0]) | {{(WORK_W-2){1'b0}}, lost};
      end
      result.invalid = (operand_a[WORD_W-2 -: EXP_W] == EXP_MAX) ||
                       (operand_b[WORD_W-2 -: EXP_W] == EXP_MAX);
      result.sub  = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
      result.sign = big[WORD_W-1];
      result.exp  = ex;
      result.mx   = mx;
      result.my   = my;
   end
endmodule
`default_nettype wire

// ===== src/fpadd_addlzc.sv =====
`default_nettype none
module fpadd_addlzc (
   input  wire fpadd_pkg::align_type op,
   output fpadd_pkg::addsum_type     result
);
   import fpadd_pkg::*;

   logic [WORK_W-1:0] sum;
   logic [LZC_W-1:0]  lz;
   logic              found;

   always_comb begin
      if (op.sub) sum = {1'b0, op.mx} - {1'b0, op.my};
      else        sum = {1'b0, op.mx} + {1'b0, op.my};
      lz = '0;
      found = 1'b0;
      // Leading zeros below the carry bit, counted from bit 26 down.
      for (int i = WORK_W-2; i >= 0; i--) begin
         if (!found && sum[i]) begin
            found = 1'b1;
            lz = LZC_W'(WORK_W-2-i);
         end
      end
      result.invalid = op.invalid;
      result.zero    = (sum == '0);
      result.sub     = op.sub;
      result.sign    = op.sign;
      result.exp     = op.exp;
      result.sum     = sum;
      result.lzc     = lz;
   end
endmodule
`default_nettype wire

// ===== src/fpadd_norm.sv =====
`default_nettype none
module fpadd_norm (
   input  wire fpadd_pkg::addsum_type op,
   output fpadd_pkg::norm_type        result
);
   import fpadd_pkg::*;

   logic [LZC_W-1:0] sh;

   always_comb begin
      result.invalid = op.invalid;
      result.zero    = op.zero;
      result.sub     = op.sub;
      result.sign    = op.sign;
      sh = '0;
      if (op.sum[WORK_W-1]) begin
         result.sum = op.sum[WORK_W-1:1] | {{(WORK_W-2){1'b0}}, op.sum[0]};
         result.exp = {1'b0, op.exp} + 9'd1;
      end else begin
         // The left shift stops where the exponent reaches one.
         if ({3'b000, op.lzc} < op.exp) sh = op.lzc;
         else sh = LZC_W'(op.exp - 8'd1);
         result.sum = op.sum[WORK_W-2:0] << sh;
         result.exp = {1'b0, op.exp} - {4'b0000, sh};
      end
   end
endmodule
`default_nettype wire

// ===== src/fpadd_round.sv =====
`default_nettype none
module fpadd_round (
   input  wire fpadd_pkg::norm_type          op,
   output logic [fpadd_pkg::WORD_W-1:0]      sum_bits,
   output logic [fpadd_pkg::STAT_W-1:0]      status
);
   import fpadd_pkg::*;

   logic [SIG_W-1:0]  sig;
   logic [SIG_W:0]    sig_r;
   logic              up;
   logic [WORD_W-1:0] bits;

   always_comb begin
      sig   = op.sum[WORK_W-2:3];
      up    = op.sum[2] && ((op.sum[1:0] != '0) || sig[0]);
      sig_r = {1'b0, sig} + {{SIG_W{1'b0}}, up};
      bits  = {op.exp - 9'd1, {FRAC_W{1'b0}}}
              + {{(WORD_W-SIG_W-1){1'b0}}, sig_r};
      if (op.invalid) begin
         sum_bits = QNAN_BITS;
         status   = STAT_INVALID;
      end else if (op.zero) begin
         sum_bits = op.sub ? '0 : {op.sign, {(WORD_W-1){1'b0}}};
         status   = STAT_OK;
      end else if (bits[WORD_W-1:FRAC_W] >= {1'b0, EXP_MAX}) begin
         sum_bits = {op.sign, EXP_MAX, {FRAC_W{1'b0}}};
         status   = STAT_OVERFLOW;
      end else begin
         sum_bits = {op.sign, bits[WORD_W-2:0]};
         status   = STAT_OK;
      end
   end
endmodule
`default_nettype wire

// ===== src/fp32_adder_round_nearest_even_core.sv =====
// Channel  | Direction | Payload
// req      | in        | req_operand_a, req_operand_b
// rsp      | out       | rsp_sum_bits, rsp_status
// Four register stages: align, add with leading-zero count, normalize, round.
// A req transfer reaches rsp valid through the align, add, normalize and round registers;
// one pair per cycle while rsp is not stalled. The pipeline advances whenever its last stage is empty or being taken.
// Reset clears all stage valid bits.
`default_nettype none
module fp32_adder_round_nearest_even_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [fpadd_pkg::WORD_W-1:0]     req_operand_a,
   input  wire logic [fpadd_pkg::WORD_W-1:0]     req_operand_b,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [fpadd_pkg::WORD_W-1:0]          rsp_sum_bits,
   output logic [fpadd_pkg::STAT_W-1:0]          rsp_status
);
   import fpadd_pkg::*;

   align_type  s1_in, s1_ff;
   addsum_type s2_in, s2_ff;
   norm_type   s3_in, s3_ff;
   logic [WORD_W-1:0] sum_in, sum_ff;
   logic [STAT_W-1:0] stat_in, stat_ff;
   logic [3:0] valid_ff;
   logic       advance;

   assign advance   = !(valid_ff[3] && rsp_stall);
   assign req_stall = !advance;

   fpadd_align  u_align (.operand_a(req_operand_a), .operand_b(req_operand_b),
                         .result(s1_in));
   fpadd_addlzc u_add   (.op(s1_ff), .result(s2_in));
   fpadd_norm   u_norm  (.op(s2_ff), .result(s3_in));
   fpadd_round  u_round (.op(s3_ff), .sum_bits(sum_in), .status(stat_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], req_valid};
      end
      if (advance) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         sum_ff  <= sum_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_valid    = valid_ff[3];
   assign rsp_sum_bits = sum_ff;
   assign rsp_status   = stat_ff;
endmodule
`default_nettype wire

// ===== src/fpadd_checker.sv =====
`default_nettype none
module fpadd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_sum_bits,
   input wire logic [1:0]  rsp_status
);
   import fpadd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_bits))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("unused status code");

   a_invalid_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_INVALID |-> rsp_sum_bits == QNAN_BITS)
      else $error("invalid result is not the quiet NaN");

   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_overflow_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OVERFLOW |-> rsp_sum_bits[30:0] == 31'h7F80_0000)
      else $error("overflow result is not infinity");
endmodule

bind fp32_adder_round_nearest_even_core fpadd_checker u_fpadd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sum_bits(rsp_sum_bits),
   .rsp_status(rsp_status));
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpadd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } operand_pair_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum_bits;
      logic [STAT_W-1:0] status;
   } fp_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [WORD_W-1:0] req_operand_a = '0;
   logic [WORD_W-1:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [WORD_W-1:0] rsp_sum_bits;
   logic [STAT_W-1:0] rsp_status;

   operand_pair_type pending_pairs[$];
   fp_sum_type expected_sums[$];
   int unsigned error_count = 0;
   int unsigned send_gap = 0;
   int unsigned drain_gap = 0;
   bit hold_for_drain = 1'b0;
   bit stimulus_done = 1'b0;

   fp32_adder_round_nearest_even_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sum_bits(rsp_sum_bits), .rsp_status(rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Rounded binary32 sum, round to nearest even, with its status code.
   function automatic fp_sum_type fp32_add_rne(logic [31:0] a, logic [31:0] b);
      fp_sum_type r;
      logic [31:0] big, lesser, mx, my, sum, e, sig, bits, d, lost;
      logic sub, sx;
      logic [31:0] ex, ey;
      r.status = STAT_OK;
      if (a[30:23] == EXP_MAX || b[30:23] == EXP_MAX) begin
         r.sum_bits = QNAN_BITS;
         r.status = STAT_INVALID;
         return r;
      end
      if (a[30:0] >= b[30:0]) begin
         big = a;
         lesser = b;
      end else begin
         big = b;
         lesser = a;
      end
      sub = a[31] ^ b[31];
      sx = big[31];
      ex = {24'd0, big[30:23]};
      ey = {24'd0, lesser[30:23]};
      mx = {9'd0, big[22:0]};
      my = {9'd0, lesser[22:0]};
      if (ex != 0) mx[23] = 1'b1; else ex = 1;
      if (ey != 0) my[23] = 1'b1; else ey = 1;
      mx = mx << 3;
      my = my << 3;
      d = ex - ey;
      if (d >= 27) begin
         my = (my != 0) ? 32'd1 : 32'd0;
      end else if (d != 0) begin
         lost = my & ((32'd1 << d) - 1);
         my = (my >> d) | ((lost != 0) ? 32'd1 : 32'd0);
      end
      sum = sub ? mx - my : mx + my;
      if (sum == 0) begin
         r.sum_bits = sub ? 32'd0 : {sx, 31'd0};
         return r;
      end
      e = ex;
      if (sum[27]) begin
         sum = (sum >> 1) | (sum & 1);
         e = e + 1;
      end else begin
         while (!sum[26] && e > 1) begin
            sum = sum << 1;
            e = e - 1;
         end
      end
      sig = sum >> 3;
      if (sum[2] && (sum[1:0] != 0 || sig[0])) sig = sig + 1;
      bits = ((e - 1) << 23) + sig;
      if ((bits >> 23) >= 32'hFF) begin
         r.sum_bits = {sx, 31'h7F80_0000};
         r.status = STAT_OVERFLOW;
         return r;
      end
      r.sum_bits = {sx, bits[30:0]};
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly finite operands with exponents close enough to interact.
   function automatic logic [31:0] random_operand(logic [7:0] near_exp);
      int unsigned kind;
      logic [31:0] v;
      kind = $urandom_range(0, 99);
      v = $urandom;
      if (kind < 60) begin
         v[30:23] = near_exp + 8'($urandom_range(0, 6)) - 8'd3;
      end else if (kind < 70) begin
         v[30:23] = 8'd0;
      end else if (kind < 76) begin
         v[30:23] = 8'($urandom_range(250, 254));
      end else if (kind < 80) begin
         v[30:23] = EXP_MAX;
      end
      return v;
   endfunction

   initial begin
      operand_pair_type p;
      logic [31:0] x;
      logic [31:0] directed[$][2];
      directed = '{
         '{32'h0000_0000, 32'h0000_0000}, '{32'h8000_0000, 32'h8000_0000},
         '{32'h0000_0000, 32'h8000_0000}, '{32'h0000_0000, 32'h3F80_0000},
         '{32'hBF80_0000, 32'h8000_0000}, '{32'h3F80_0000, 32'hBF80_0000},
         '{32'h3F80_0000, 32'h3F80_0000}, '{32'h7F7F_FFFF, 32'h7F7F_FFFF},
         '{32'hFF7F_FFFF, 32'hFF7F_FFFF}, '{32'h7F80_0000, 32'h3F80_0000},
         '{32'h3F80_0000, 32'hFFC0_0001}, '{32'h7FFF_FFFF, 32'hFF80_0000},
         '{32'h0000_0001, 32'h0000_0001}, '{32'h007F_FFFF, 32'h0000_0001},
         '{32'h0080_0000, 32'h8000_0001}, '{32'h0080_0001, 32'h8080_0000},
         '{32'h3F80_0000, 32'h3380_0000}, '{32'h3F80_0001, 32'h3380_0000},
         '{32'h3F80_0000, 32'hB380_0001}, '{32'h4B7F_FFFF, 32'h3F00_0000},
         '{32'h7F7F_FFFF, 32'h7380_0000}, '{32'hFFFF_FFFF, 32'h0000_0000},
         '{32'h3F80_0000, 32'h0000_0001}, '{32'hC000_0000, 32'h3FFF_FFFF}
      };
      foreach (directed[i]) begin
         p.a = directed[i][0];
         p.b = directed[i][1];
         pending_pairs.push_back(p);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < 630; n++) begin
         if (n == 300) begin
            wait (pending_pairs.size() == 0);
            hold_for_drain = 1'b1;
            wait (expected_sums.size() == 0);
            @(posedge clock);
            hold_for_drain = 1'b0;
         end
         x = $urandom;
         p.a = random_operand(x[7:0]);
         p.b = random_operand(p.a[30:23]);
         // Near cancellation: opposite signs and almost equal magnitudes.
         if ($urandom_range(0, 9) == 0) begin
            p.b = {~p.a[31], p.a[30:0] ^ 31'($urandom_range(0, 15))};
         end
         pending_pairs.push_back(p);
      end
      stimulus_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         // The item at the head of the queue is the one on the bus until its transfer.
         if (req_valid) pending_pairs.pop_front();
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > 0 && !hold_for_drain) begin
            p_drive: begin
               operand_pair_type nxt;
               nxt = pending_pairs[0];
               req_valid <= 1'b1;
               req_operand_a <= nxt.a;
               req_operand_b <= nxt.b;
               expected_sums.push_back(fp32_add_rne(nxt.a, nxt.b));
               send_gap <= pick_gap();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      fp_sum_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               $error("result transfer with nothing expected: sum_bits %h status %0d",
                      rsp_sum_bits, rsp_status);
               error_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_sum_bits !== want.sum_bits) begin
                  $error("sum_bits expected %h actual %h", want.sum_bits, rsp_sum_bits);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (drain_gap != 0) begin
            drain_gap <= drain_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            drain_gap <= pick_gap();
         end
      end
   end

   initial begin
      wait (stimulus_done && pending_pairs.size() == 0 && !req_valid);
      wait (expected_sums.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_sums.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
